[design/skpq_pkg.sv]
// Shared types, codes and default sizes for the sorted key priority queue.
// No dependencies.
package skpq_pkg;

  localparam int CAPACITY_DEF     = 16;
  localparam int KEY_CHARS_DEF    = 6;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam int KEY_W = 48;
  localparam int PAY_W = 32;

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_POP    = 2'd1;
  localparam logic [1:0] FN_DELETE = 2'd2;
  localparam logic [1:0] FN_DUMP   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]       status;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;
    logic             last;
  } result_t;

endpackage

[design/skpq_out.sv]
// Output register stage for the sorted key priority queue result stream.
// Depends on skpq_pkg.
module skpq_out
  import skpq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push_valid,
  output logic                     push_ready,
  input  result_t                  push_data,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [KEY_W+PAY_W-1:0]   m_axis_tdata,
  output logic [1:0]               m_axis_tuser,
  output logic                     m_axis_tlast
);

  logic    valid;
  result_t beat;

  assign push_ready = !valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push_ready) begin
      valid <= push_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ready && push_valid) begin
      beat <= push_data;
    end
  end

  assign m_axis_tvalid = valid;
  assign m_axis_tdata  = {beat.pay, beat.key};
  assign m_axis_tuser  = beat.status;
  assign m_axis_tlast  = beat.last;

endmodule

[design/sorted_key_priority_queue_top.sv]
// Top level of the sorted key priority queue: sequencer, entry memory, compare unit.
// Depends on skpq_pkg and skpq_out.
//
// Keeps up to CAPACITY key/payload entries in ascending key order in one
// memory with a registered read port; one key comparator steps through it under
// a small sequencer, and the input is not ready until the operation is done.
// Each memory step is a read, then a compare or a write. Insert, pop and delete
// step through up to all stored entries, dump reads each of them and a rejected
// command goes straight to its result; an output stall holds the sequencer. A
// finished result waits in an output register while the next command is taken.
module sorted_key_priority_queue_top
  import skpq_pkg::*;
#(
  parameter int CAPACITY     = CAPACITY_DEF,
  parameter int KEY_CHARS    = KEY_CHARS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [KEY_W+PAY_W-1:0] s_axis_tdata,  // key_in, payload_in
  input  logic [1:0]             s_axis_tuser,  // func
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [KEY_W+PAY_W-1:0] m_axis_tdata,  // key_out, payload_out
  output logic [1:0]             m_axis_tuser,  // status
  output logic                   m_axis_tlast   // last_of_run
);

  localparam int KEY_BITS  = 8 * KEY_CHARS;
  localparam int ENTRY_W   = KEY_BITS + PAYLOAD_BITS;
  localparam int ADDR_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_INS_RD   = 4'd1;
  localparam logic [3:0] S_INS_CMP  = 4'd2;
  localparam logic [3:0] S_INS_PUT  = 4'd3;
  localparam logic [3:0] S_SRCH_RD  = 4'd4;
  localparam logic [3:0] S_SRCH_CMP = 4'd5;
  localparam logic [3:0] S_SHF_RD   = 4'd6;
  localparam logic [3:0] S_SHF_WR   = 4'd7;
  localparam logic [3:0] S_DMP_RD   = 4'd8;
  localparam logic [3:0] S_DMP_OUT  = 4'd9;
  localparam logic [3:0] S_RES      = 4'd10;

  logic [3:0]              state, state_next;
  logic [ADDR_BITS-1:0]    idx, idx_next, idx_inc;
  logic [CNT_BITS-1:0]     count, count_next, idx_plus;
  logic [KEY_BITS-1:0]     op_key, op_key_next, rkey, key_fit;
  logic [PAYLOAD_BITS-1:0] op_pay, op_pay_next, rpay, pay_fit;
  logic                    op_pop, op_pop_next;
  result_t                 res, res_next, push_data;
  logic                    push_valid, push_ready;
  logic                    full, empty, accept;

  logic [ENTRY_W-1:0]      mem [CAPACITY];
  logic [ENTRY_W-1:0]      rdata, mem_wd;
  logic [ADDR_BITS-1:0]    mem_wa, mem_ra;
  logic                    mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata <= mem[mem_ra];
  end

  assign rkey     = rdata[KEY_BITS-1:0];
  assign rpay     = rdata[ENTRY_W-1:KEY_BITS];
  assign key_fit  = KEY_BITS'(s_axis_tdata[KEY_W-1:0]);
  assign pay_fit  = PAYLOAD_BITS'(s_axis_tdata[KEY_W+PAY_W-1:KEY_W]);
  assign idx_inc  = idx + 1'b1;
  assign idx_plus = CNT_BITS'(idx) + CNT_BITS'(1);
  assign full     = (count == CNT_BITS'(CAPACITY));
  assign empty    = (count == '0);
  assign mem_ra   = (state == S_SHF_RD) ? idx_inc : idx;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    count_next  = count;
    op_key_next = op_key;
    op_pay_next = op_pay;
    op_pop_next = op_pop;
    res_next    = res;
    mem_we      = 1'b0;
    mem_wa      = idx_inc;
    mem_wd      = rdata;
    push_valid  = 1'b0;
    push_data   = res;
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_key_next     = key_fit;
          op_pay_next     = pay_fit;
          op_pop_next     = (s_axis_tuser == FN_POP);
          idx_next        = '0;
          res_next.status = ST_OK;
          res_next.key    = '0;
          res_next.pay    = '0;
          res_next.last   = 1'b1;
          unique case (s_axis_tuser)
            FN_INSERT: begin
              if (full) begin
                res_next.status = ST_FULL;
                state_next      = S_RES;
              end else if (empty) begin
                state_next = S_INS_PUT;
              end else begin
                idx_next   = ADDR_BITS'(count - 1'b1);
                state_next = S_INS_RD;
              end
            end
            FN_POP: begin
              if (empty) begin
                res_next.status = ST_EMPTY;
                state_next      = S_RES;
              end else begin
                state_next = S_SRCH_RD;
              end
            end
            FN_DELETE: begin
              if (empty) begin
                res_next.status = ST_NOT_FOUND;
                state_next      = S_RES;
              end else begin
                state_next = S_SRCH_RD;
              end
            end
            FN_DUMP: begin
              if (empty) begin
                res_next.status = ST_EMPTY;
                state_next      = S_RES;
              end else begin
                state_next = S_DMP_RD;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_INS_RD: state_next = S_INS_CMP;
      S_INS_CMP: begin
        mem_we = 1'b1;
        if (rkey > op_key) begin
          if (idx == '0) begin
            state_next = S_INS_PUT;
          end else begin
            idx_next   = idx - 1'b1;
            state_next = S_INS_RD;
          end
        end else begin
          mem_wd     = {op_pay, op_key};
          count_next = count + 1'b1;
          state_next = S_RES;
        end
      end
      S_INS_PUT: begin
        mem_we     = 1'b1;
        mem_wa     = idx;
        mem_wd     = {op_pay, op_key};
        count_next = count + 1'b1;
        state_next = S_RES;
      end
      S_SRCH_RD: state_next = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (op_pop || rkey == op_key) begin
          if (op_pop) begin
            res_next.key = KEY_W'(rkey);
            res_next.pay = PAY_W'(rpay);
          end
          state_next = S_SHF_RD;
        end else if (idx_plus == count) begin
          res_next.status = ST_NOT_FOUND;
          state_next      = S_RES;
        end else begin
          idx_next   = idx_inc;
          state_next = S_SRCH_RD;
        end
      end
      S_SHF_RD: begin
        if (idx_plus >= count) begin
          count_next = count - 1'b1;
          state_next = S_RES;
        end else begin
          state_next = S_SHF_WR;
        end
      end
      S_SHF_WR: begin
        mem_we     = 1'b1;
        mem_wa     = idx;
        idx_next   = idx_inc;
        state_next = S_SHF_RD;
      end
      S_DMP_RD: state_next = S_DMP_OUT;
      S_DMP_OUT: begin
        push_valid       = 1'b1;
        push_data.status = ST_OK;
        push_data.key    = KEY_W'(rkey);
        push_data.pay    = PAY_W'(rpay);
        push_data.last   = (idx_plus == count);
        if (push_ready) begin
          if (idx_plus == count) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx_inc;
            state_next = S_DMP_RD;
          end
        end
      end
      S_RES: begin
        push_valid = 1'b1;
        if (push_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    op_key <= op_key_next;
    op_pay <= op_pay_next;
    op_pop <= op_pop_next;
    res    <= res_next;
  end

  skpq_out u_out (
    .clk           (clk),
    .rst           (rst),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_data     (push_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count == $past(count)) || (count == $past(count) + 1'b1) ||
    (count + 1'b1 == $past(count)))
    else $error("entry count jumped");

  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    (accept && s_axis_tuser == FN_INSERT && full) |=>
    (state == S_RES && res.status == ST_FULL && count == $past(count)))
    else $error("insert into full store not rejected");

  a_idle_no_push: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !push_valid)
    else $error("result pushed while taking commands");

endmodule
